FILE: rtl/i2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared constants, types and character classes for the infix to postfix
// converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CHAR_W      = 8;

  localparam logic [CHAR_W-1:0] CH_CARET  = 8'h5E;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_LSQ    = 8'h5B;
  localparam logic [CHAR_W-1:0] CH_LCURLY = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_RSQ    = 8'h5D;
  localparam logic [CHAR_W-1:0] CH_RCURLY = 8'h7D;
  localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z   = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z   = 8'h7A;

  typedef enum logic [1:0] {
    KIND_SYMBOL,
    KIND_DONE,
    KIND_UNBAL,
    KIND_OVERFLOW
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              clear;
    logic [CHAR_W-1:0] data;
  } stack_cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic [CHAR_W-1:0] top;
  } stack_stat_t;

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    kind_t             kind;
  } result_t;

  function automatic logic [1:0] prio(input logic [CHAR_W-1:0] ch);
    logic [1:0] p;
    case (ch)
      CH_CARET:           p = 2'd3;
      CH_STAR, CH_SLASH:  p = 2'd2;
      CH_PLUS, CH_MINUS:  p = 2'd1;
      default:            p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_open(input logic [CHAR_W-1:0] ch);
    return (ch == CH_LPAREN) || (ch == CH_LSQ) || (ch == CH_LCURLY);
  endfunction

  function automatic logic is_close(input logic [CHAR_W-1:0] ch);
    return (ch == CH_RPAREN) || (ch == CH_RSQ) || (ch == CH_RCURLY);
  endfunction

  function automatic logic is_blank(input logic [CHAR_W-1:0] ch);
    return (ch == CH_SPACE) || ((ch >= CH_TAB) && (ch <= CH_CR));
  endfunction

  function automatic logic is_alnum(input logic [CHAR_W-1:0] ch);
    return ((ch >= CH_ZERO) && (ch <= CH_NINE)) ||
           ((ch >= CH_UP_A) && (ch <= CH_UP_Z)) ||
           ((ch >= CH_LO_A) && (ch <= CH_LO_Z));
  endfunction

  function automatic logic [CHAR_W-1:0] open_of(input logic [CHAR_W-1:0] ch);
    logic [CHAR_W-1:0] o;
    case (ch)
      CH_RPAREN: o = CH_LPAREN;
      CH_RSQ:    o = CH_LSQ;
      default:   o = CH_LCURLY;
    endcase
    return o;
  endfunction

endpackage

FILE: rtl/i2p_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module i2p_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/i2p_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_stack
// Operator stack held in RAM; keeps the count and presents the top entry,
// taken from the read port after a pop and from a register after a push.
// ----------------------------------------------------------------------------
module i2p_stack
  import i2p_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  stack_cmd_t  cmd,
  output stack_stat_t stat
);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  cnt_m2;
  logic [CHAR_W-1:0] top_reg;
  logic              top_sel;
  logic [CHAR_W-1:0] rd_data;
  logic              rd_en;

  assign cnt_m2 = count - CNT_W'(2);
  assign rd_en  = cmd.pop && (count >= CNT_W'(2));

  i2p_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (CHAR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.push),
    .wr_addr (count[ADDR_W-1:0]),
    .wr_data (cmd.data),
    .rd_en   (rd_en),
    .rd_addr (cnt_m2[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      top_sel <= 1'b0;
    end else if (cmd.clear) begin
      count <= '0;
    end else if (cmd.push) begin
      count   <= count + CNT_W'(1);
      top_sel <= 1'b0;
    end else if (cmd.pop) begin
      count   <= count - CNT_W'(1);
      top_sel <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      top_reg <= cmd.data;
    end
  end

  assign stat.count = count;
  assign stat.top   = top_sel ? rd_data : top_reg;

endmodule

FILE: rtl/i2p_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ctrl
// Per-item sequencer: classifies the character, drives stack pushes and
// pops, and holds one result back so the final one can carry last.
// ----------------------------------------------------------------------------
module i2p_ctrl
  import i2p_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,
  output logic [1:0]  m_tuser,
  output logic        m_tlast,
  input  stack_stat_t stat,
  output stack_cmd_t  cmd
);

  state_t            state;
  state_t            state_next;
  logic [CHAR_W-1:0] ch_q;
  logic              end_q;
  logic              skipping;
  logic              pend_v;
  result_t           pend;

  logic              emit;
  logic              done;
  result_t           res_new;
  stack_cmd_t        cmd_raw;
  logic              skip_set;
  logic              skip_clr;
  logic              stack_full;
  logic              nonempty;
  logic              need_out;
  logic              out_free;
  logic              go;

  logic              load_out;
  result_t           out_res;
  logic              out_last;
  logic              pend_load;
  logic              pend_clr;

  assign stack_full = stat.count >= CNT_W'(STACK_DEPTH);
  assign nonempty   = stat.count != '0;
  assign out_free   = !m_tvalid || m_tready;

  // action for one step of the current item
  always_comb begin
    emit     = 1'b0;
    done     = 1'b0;
    res_new  = '{ch: '0, kind: KIND_SYMBOL};
    cmd_raw  = '{push: 1'b0, pop: 1'b0, clear: 1'b0, data: ch_q};
    skip_set = 1'b0;
    skip_clr = 1'b0;
    if (end_q) begin
      if (skipping) begin
        skip_clr      = 1'b1;
        cmd_raw.clear = 1'b1;
        done          = 1'b1;
      end else if (nonempty && !is_open(stat.top)) begin
        emit        = 1'b1;
        res_new.ch  = stat.top;
        cmd_raw.pop = 1'b1;
      end else begin
        emit          = 1'b1;
        res_new.kind  = nonempty ? KIND_UNBAL : KIND_DONE;
        cmd_raw.clear = 1'b1;
        done          = 1'b1;
      end
    end else if (skipping || is_blank(ch_q)) begin
      done = 1'b1;
    end else if (is_alnum(ch_q)) begin
      emit       = 1'b1;
      res_new.ch = ch_q;
      done       = 1'b1;
    end else if (is_close(ch_q)) begin
      if (nonempty && !is_open(stat.top)) begin
        emit        = 1'b1;
        res_new.ch  = stat.top;
        cmd_raw.pop = 1'b1;
      end else if (nonempty && (stat.top == open_of(ch_q))) begin
        cmd_raw.pop = 1'b1;
        done        = 1'b1;
      end else begin
        emit          = 1'b1;
        res_new.kind  = KIND_UNBAL;
        cmd_raw.clear = 1'b1;
        skip_set      = 1'b1;
        done          = 1'b1;
      end
    end else if (!is_open(ch_q) && nonempty && (prio(ch_q) <= prio(stat.top))) begin
      emit        = 1'b1;
      res_new.ch  = stat.top;
      cmd_raw.pop = 1'b1;
    end else if (stack_full) begin
      emit          = 1'b1;
      res_new.kind  = KIND_OVERFLOW;
      cmd_raw.clear = 1'b1;
      skip_set      = 1'b1;
      done          = 1'b1;
    end else begin
      cmd_raw.push = 1'b1;
      done         = 1'b1;
    end
  end

  assign need_out = emit ? (pend_v || done) : (done && pend_v);
  assign go       = (state == ST_RUN) && !(need_out && !out_free);

  // result routing through the held slot
  always_comb begin
    load_out  = 1'b0;
    out_res   = pend;
    out_last  = 1'b0;
    pend_load = 1'b0;
    pend_clr  = 1'b0;
    if (go) begin
      if (emit && pend_v) begin
        load_out  = 1'b1;
        pend_load = 1'b1;
      end else if (emit) begin
        if (done) begin
          load_out = 1'b1;
          out_res  = res_new;
          out_last = 1'b1;
        end else begin
          pend_load = 1'b1;
        end
      end else if (done && pend_v) begin
        load_out = 1'b1;
        out_last = 1'b1;
        pend_clr = 1'b1;
      end
    end else if ((state == ST_FLUSH) && out_free) begin
      load_out = 1'b1;
      out_last = 1'b1;
      pend_clr = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (go && done) begin
          state_next = (emit && pend_v) ? ST_FLUSH : ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready  = (state == ST_IDLE);
    cmd       = cmd_raw;
    cmd.push  = cmd_raw.push && go;
    cmd.pop   = cmd_raw.pop && go;
    cmd.clear = cmd_raw.clear && go;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      skipping <= 1'b0;
      pend_v   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (go && skip_set) begin
        skipping <= 1'b1;
      end else if (go && skip_clr) begin
        skipping <= 1'b0;
      end
      if (pend_load) begin
        pend_v <= 1'b1;
      end else if (pend_clr) begin
        pend_v <= 1'b0;
      end
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ch_q  <= s_tdata;
      end_q <= s_tlast;
    end
    if (pend_load) begin
      pend <= res_new;
    end
    if (load_out) begin
      m_tdata <= out_res.ch;
      m_tuser <= out_res.kind;
      m_tlast <= out_last;
    end
  end

endmodule

FILE: rtl/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters and
// expression status out, operator stack kept in a RAM.
// ----------------------------------------------------------------------------
//   channel  | direction | tdata          | tuser      | tlast
//   s_*      | in        | in_char [7:0]  | -          | is_end
//   m_*      | out       | out_char [7:0] | kind [1:0] | last
//
// an item that passes a symbol or pushes is accepted, then executed
// each entry popped before the final step adds an execute step; the stack RAM read
// port delivers the new top in the cycle after the pop
// an end marker or failing bracket that popped adds a flush step for the held item
// one item is taken at a time; a full output register stalls the sequencer
// reset clears count, error flag and handshakes; no memory clearing pass
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
  import i2p_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // in_char [7:0]
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // out_char [7:0]
  output logic [1:0] m_tuser,   // kind [1:0]
  output logic       m_tlast
);

  stack_cmd_t  cmd;
  stack_stat_t stat;

  i2p_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .stat     (stat),
    .cmd      (cmd)
  );

  i2p_stack u_stack (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat)
  );

endmodule

FILE: rtl/i2p_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_checker
// Port-level checks for the infix to postfix converter.
// ----------------------------------------------------------------------------
module i2p_checker
  import i2p_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       s_tvalid,
  input logic       s_tready,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic [1:0] m_tuser,
  input logic       m_tlast
);

  // held item must not change
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
      && $stable(m_tlast))
    else $error("output item changed while stalled");

  // status results always close the item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_SYMBOL) |-> m_tlast)
    else $error("status result without last");

  a_status_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != KIND_SYMBOL) |-> (m_tdata == 8'h00))
    else $error("status result with nonzero character");

  // one item in flight
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while busy");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output valid straight after reset");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (.*);
